[rtl/lpd_pkg.sv]
package lpd_pkg;

  // Header layout: 4 length bytes, then 2 type bytes, big-endian.
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned LENGTH_BYTES = 4;

  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  // Default depth of the result queue.
  localparam int unsigned RESULT_DEPTH = 4;

  // Summary status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_LEN_LOW   = 2'd2;
  localparam logic [1:0] STATUS_LEN_OVER  = 2'd3;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  payload_byte;
    logic [15:0] packet_type;
    logic [31:0] packet_length;
    logic [1:0]  status;
    logic        complete;
    logic        last;
  } lpd_result_t;

endpackage

[rtl/length_prefixed_packet_deframer.sv]
// Channel  Handshake             Fields
// input    in_valid / in_stall   data_byte, end_of_buffer
// output   out_valid / out_stall is_summary, payload_byte, packet_type,
//                                packet_length, status, complete, last
//
// Takes one word per cycle while in_stall is low, parsing it the same cycle.
// Results are registered in a small result queue and read out one word per
// cycle while out_stall is low. A buffer-end byte that also carries payload
// yields two words. in_stall is high while the queue has fewer than two free
// entries. rst is synchronous and clears parser state and queue pointers.
module length_prefixed_packet_deframer import lpd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = RESULT_DEPTH  // 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_summary,
  output logic [7:0]  payload_byte,
  output logic [15:0] packet_type,
  output logic [31:0] packet_length,
  output logic [1:0]  status,
  output logic        complete,
  output logic        last
);

  logic        accept;
  logic        room;
  logic [1:0]  res_count;
  lpd_result_t res0;
  lpd_result_t res1;
  lpd_result_t head;

  // Accept only with space for the worst case of two result words.
  assign in_stall = !room;
  assign accept   = in_valid && room;

  // Header capture, position tracking and result build.
  lpd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .res_count     (res_count),
    .res0          (res0),
    .res1          (res1)
  );

  // Two-in, one-out queue decoupling the output from the input.
  lpd_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_count (res_count),
    .wr0      (res0),
    .wr1      (res1),
    .room     (room),
    .rd_valid (out_valid),
    .rd_take  (!out_stall),
    .rd_data  (head)
  );

  assign is_summary    = head.is_summary;
  assign payload_byte  = head.payload_byte;
  assign packet_type   = head.packet_type;
  assign packet_length = head.packet_length;
  assign status        = head.status;
  assign complete      = head.complete;
  assign last          = head.last;

endmodule

[rtl/lpd_parser.sv]
module lpd_parser import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic [1:0]  res_count,
  output lpd_result_t res0,
  output lpd_result_t res1
);

  logic [31:0] byte_position;
  logic [31:0] length_accumulator;
  logic [15:0] type_accumulator;

  logic [31:0] byte_position_next;
  logic [31:0] length_next;
  logic [15:0] type_next;
  logic [31:0] size;
  logic        in_length;
  logic        in_type;
  logic        pay_hit;
  lpd_result_t pay_res;
  lpd_result_t sum_res;

  always_comb begin
    in_length = byte_position < 32'(LENGTH_BYTES);
    in_type   = !in_length && (byte_position < 32'(HEADER_BYTES));

    length_next = in_length ? {length_accumulator[23:0], data_byte} : length_accumulator;
    type_next   = in_type ? {type_accumulator[7:0], data_byte} : type_accumulator;

    pay_hit = !in_length && !in_type && (byte_position != POS_MAX) &&
              (length_accumulator >= 32'(HEADER_BYTES)) &&
              (byte_position < length_accumulator);

    byte_position_next = (byte_position == POS_MAX) ? POS_MAX : byte_position + 32'd1;
    size = byte_position_next;

    pay_res               = '0;
    pay_res.payload_byte  = data_byte;
    pay_res.last          = !end_of_buffer;

    sum_res            = '0;
    sum_res.is_summary = 1'b1;
    sum_res.last       = 1'b1;
    if (size < 32'(HEADER_BYTES)) begin
      sum_res.status = STATUS_SHORT;
    end else begin
      sum_res.packet_type   = type_next;
      sum_res.packet_length = length_next;
      sum_res.complete      = (length_next <= size);
      if (length_next < 32'(HEADER_BYTES)) begin
        sum_res.status = STATUS_LEN_LOW;
      end else if (length_next > size) begin
        sum_res.status = STATUS_LEN_OVER;
      end else begin
        sum_res.status = STATUS_OK;
      end
    end

    // Payload goes out ahead of the summary when both come from one byte.
    res_count = 2'd0;
    res0      = sum_res;
    res1      = sum_res;
    if (accept) begin
      if (pay_hit) begin
        res0      = pay_res;
        res_count = end_of_buffer ? 2'd2 : 2'd1;
      end else begin
        res_count = end_of_buffer ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      length_accumulator <= '0;
      type_accumulator   <= '0;
    end else if (accept) begin
      if (end_of_buffer) begin
        byte_position      <= '0;
        length_accumulator <= '0;
        type_accumulator   <= '0;
      end else begin
        byte_position      <= byte_position_next;
        length_accumulator <= length_next;
        type_accumulator   <= type_next;
      end
    end
  end

endmodule

[rtl/lpd_result_queue.sv]
module lpd_result_queue import lpd_pkg::*; #(
  parameter int unsigned DEPTH = RESULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  wr_count,
  input  lpd_result_t wr0,
  input  lpd_result_t wr1,
  output logic        room,
  output logic        rd_valid,
  input  logic        rd_take,
  output lpd_result_t rd_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpd_result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] wr_ptr_plus1;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [1:0] inc);
    logic [PTR_W+1:0] sum;
    sum = (PTR_W+2)'(ptr) + (PTR_W+2)'(inc);
    if (sum >= (PTR_W+2)'(DEPTH)) begin
      sum = sum - (PTR_W+2)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign rd_valid     = (count != '0);
  assign rd_data      = entries[rd_ptr];
  assign pop          = rd_valid && rd_take;
  assign room         = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr_plus1 = ptr_add(wr_ptr, 2'd1);
  assign count_next   = count + CNT_W'(wr_count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      entries[wr_ptr] <= wr0;
    end
    if (wr_count == 2'd2) begin
      entries[wr_ptr_plus1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= ptr_add(wr_ptr, wr_count);
      rd_ptr <= ptr_add(rd_ptr, {1'b0, pop});
      count  <= count_next;
    end
  end

endmodule

[test/tb_length_prefixed_packet_deframer.sv]
module tb_length_prefixed_packet_deframer;
  import lpd_pkg::*;

  // Hard stop for a hung run.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Words of random buffers per idling phase.
  localparam int unsigned PHASE_WORDS  = 140;
  // Receiver hold-off length in phase 2, long enough to fill the block.
  localparam int unsigned HOLD_CYCLES  = 64;
  // Drain time after the last expected word.
  localparam int unsigned DRAIN_CYCLES = 20;

  // One input word: a buffer byte plus its end-of-buffer mark.
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } buffer_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_summary;
  logic [7:0]  payload_byte;
  logic [15:0] packet_type;
  logic [31:0] packet_length;
  logic [1:0]  status;
  logic        complete;
  logic        last;

  // Stimulus and scoreboard storage.
  buffer_byte_t buffer_bytes[$];
  lpd_result_t  deframed_words_due[$];

  // Predictor copy of the parser state.
  logic [31:0] parser_pos    = '0;
  logic [31:0] parsed_length = '0;
  logic [15:0] parsed_type   = '0;

  int unsigned phase        = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          word_taken   = 1'b0;
  lpd_result_t got_word;
  lpd_result_t want_word;

  length_prefixed_packet_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_summary   (is_summary),
    .payload_byte (payload_byte),
    .packet_type  (packet_type),
    .packet_length(packet_length),
    .status       (status),
    .complete     (complete),
    .last         (last)
  );

  always #5 clk = ~clk;

  // Predictor: consume one accepted byte, queue the words it should produce.
  // Header bytes build the length/type fields; payload passes only when the
  // length covers the header and this position is still inside the packet.
  task automatic deframe_byte(input logic [7:0] b, input logic eob);
    lpd_result_t w;
    logic [31:0] bytes_seen;
    w = '0;
    if (parser_pos < LENGTH_BYTES) begin
      parsed_length = {parsed_length[23:0], b};
    end else if (parser_pos < HEADER_BYTES) begin
      parsed_type = {parsed_type[7:0], b};
    end else if (parser_pos != POS_MAX && parsed_length >= HEADER_BYTES &&
                 parser_pos < parsed_length) begin
      w.payload_byte = b;
      w.last = !eob;  // summary follows on a buffer-end byte
      deframed_words_due.push_back(w);
    end
    // position and byte count both saturate
    bytes_seen = (parser_pos == POS_MAX) ? POS_MAX : parser_pos + 1;
    if (parser_pos != POS_MAX) parser_pos = parser_pos + 1;
    if (eob) begin
      w = '0;
      w.is_summary = 1'b1;
      w.last = 1'b1;
      if (bytes_seen < HEADER_BYTES) begin
        w.status = STATUS_SHORT;  // type/length stay 0, not complete
      end else begin
        w.packet_type   = parsed_type;
        w.packet_length = parsed_length;
        w.complete      = (parsed_length <= bytes_seen);
        if (parsed_length < HEADER_BYTES) w.status = STATUS_LEN_LOW;
        else if (parsed_length > bytes_seen) w.status = STATUS_LEN_OVER;
        else w.status = STATUS_OK;
      end
      deframed_words_due.push_back(w);
      parser_pos    = '0;
      parsed_length = '0;
      parsed_type   = '0;
    end
  endtask

  // Queue one buffer of n_bytes: big-endian length, type, random payload.
  // Buffers shorter than the header get a truncated header.
  task automatic queue_buffer(input logic [31:0] hdr_len, input logic [15:0] hdr_type,
                              input int unsigned n_bytes);
    logic [47:0] header;
    buffer_byte_t w;
    header = {hdr_len, hdr_type};
    for (int unsigned i = 0; i < n_bytes; i++) begin
      w.data = (i < HEADER_BYTES) ? header[47 - 8*i -: 8] : 8'($urandom());
      w.eob  = (i == n_bytes - 1);
      buffer_bytes.push_back(w);
    end
  endtask

  // Random buffers for one phase: the largest share well formed with exact length,
  // the rest trailing junk, low length, overrun, wild length or short.
  task automatic queue_random_buffers(input int unsigned n_words);
    int unsigned queued;
    int unsigned n_bytes;
    int unsigned pick;
    logic [31:0] hdr_len;
    queued = 0;
    while (queued < n_words) begin
      n_bytes = ($urandom_range(99) < 88) ? $urandom_range(24, HEADER_BYTES)
                                          : $urandom_range(HEADER_BYTES - 1, 1);
      pick = $urandom_range(99);
      if (n_bytes < HEADER_BYTES) hdr_len = $urandom();
      else if (pick < 50) hdr_len = n_bytes;
      else if (pick < 65 && n_bytes > HEADER_BYTES)
        hdr_len = $urandom_range(n_bytes - 1, HEADER_BYTES);  // bytes past length
      else if (pick < 75) hdr_len = $urandom_range(HEADER_BYTES - 1, 0);
      else if (pick < 88) hdr_len = n_bytes + $urandom_range(10, 1);
      else hdr_len = $urandom();
      queue_buffer(hdr_len, 16'($urandom()), n_bytes);
      queued += n_bytes;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Input side: note acceptance at the rising edge and run the predictor.
  always @(posedge clk) begin
    word_taken = !rst && in_valid && !in_stall;
    if (word_taken) deframe_byte(data_byte, end_of_buffer);
  end

  // Driver: holds a stalled word, otherwise offers the next one or idles.
  // in_valid gets at most one assignment per falling edge.
  always @(negedge clk) begin
    buffer_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (buffer_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = buffer_bytes.pop_front();
        data_byte     <= nxt.data;
        end_of_buffer <= nxt.eob;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, plus one long hold-off in phase 2 while the
  // sender keeps going, so the result queue fills and in_stall rises.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (phase == 2 && !hold_done && buffer_bytes.size() < PHASE_WORDS - 30) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Monitor: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_word = '{is_summary, payload_byte, packet_type, packet_length,
                   status, complete, last};
      if (deframed_words_due.size() == 0) begin
        $error("unexpected word: 0x%0h", got_word);
        mismatches++;
      end else begin
        want_word = deframed_words_due.pop_front();
        check_field("is_summary", want_word.is_summary, got_word.is_summary);
        check_field("payload_byte", want_word.payload_byte, got_word.payload_byte);
        check_field("packet_type", want_word.packet_type, got_word.packet_type);
        check_field("packet_length", want_word.packet_length, got_word.packet_length);
        check_field("status", want_word.status, got_word.status);
        check_field("complete", want_word.complete, got_word.complete);
        check_field("last", want_word.last, got_word.last);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: one-byte buffer (short), all-ones length over a bare header
    // with zero type, exact-length buffer whose last byte is payload, and a
    // length below the header with bytes left over.
    queue_buffer(32'hFF00_0000, 16'h0000, 1);
    queue_buffer(32'hFFFF_FFFF, 16'h0000, HEADER_BYTES);
    queue_buffer(32'd8, 16'hFFFF, 8);
    queue_buffer(32'd5, 16'hA55A, 8);

    for (int unsigned ph = 0; ph < 3; ph++) begin
      phase = ph;
      case (ph)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 59;
        end
        1: begin
          tx_idle_pct = 59;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      queue_random_buffers(PHASE_WORDS);
      // sender pauses here until the block has fully drained
      while (buffer_bytes.size() != 0 || in_valid) @(posedge clk);
      while (deframed_words_due.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && deframed_words_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
